@@ src/jpeg_header_dimension_probe_top_assert.svh @@
// ----------------------------------------------------------------------------
// jpeg header dimension probe assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef JPEG_HEADER_DIMENSION_PROBE_TOP_ASSERT_SVH
`define JPEG_HEADER_DIMENSION_PROBE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JHDP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jhdp assertion failed");

// next-cycle implication, disabled during reset
`define JHDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jhdp assertion failed");

`endif

@@ src/jhdp_pkg.sv @@
// ----------------------------------------------------------------------------
// jhdp_pkg
// types, marker codes and helpers for the jpeg header dimension probe
// ----------------------------------------------------------------------------
package jhdp_pkg;

	localparam logic [7:0] MK_FILL  = 8'hFF;
	localparam logic [7:0] MK_SOI   = 8'hD8;
	localparam logic [7:0] MK_TEM   = 8'h01;
	localparam logic [7:0] MK_RST0  = 8'hD0;
	localparam logic [7:0] MK_RST7  = 8'hD7;
	localparam logic [7:0] MK_EOI   = 8'hD9;
	localparam logic [7:0] MK_SOS   = 8'hDA;
	localparam logic [7:0] MK_SOF0  = 8'hC0;
	localparam logic [7:0] MK_SOF1  = 8'hC1;
	localparam logic [7:0] MK_SOF2  = 8'hC2;
	localparam logic [7:0] MK_SOF15 = 8'hCF;
	localparam logic [7:0] MK_DHT   = 8'hC4;
	localparam logic [7:0] MK_JPG   = 8'hC8;
	localparam logic [7:0] MK_DAC   = 8'hCC;

	localparam logic [1:0] ST_UNKNOWN  = 2'd0;
	localparam logic [1:0] ST_BASELINE = 2'd1;
	localparam logic [1:0] ST_UNSUPP   = 2'd2;

	typedef enum logic [9:0] {
		PH_IDLE = 10'b00_0000_0001,
		PH_SOI1 = 10'b00_0000_0010,
		PH_SOI2 = 10'b00_0000_0100,
		PH_MK0  = 10'b00_0000_1000,
		PH_MK1  = 10'b00_0001_0000,
		PH_LEN0 = 10'b00_0010_0000,
		PH_LEN1 = 10'b00_0100_0000,
		PH_SKIP = 10'b00_1000_0000,
		PH_SOF  = 10'b01_0000_0000,
		PH_DONE = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic       end_of_data;
		logic       first_byte;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] image_height;
		logic [15:0] image_width;
		logic [1:0]  probe_status;
	} result_t;

	function automatic logic is_unsupp_sof(input logic [7:0] code);
		return (code >= MK_SOF2) && (code <= MK_SOF15) && (code != MK_DHT)
			&& (code != MK_JPG) && (code != MK_DAC);
	endfunction

endpackage

@@ src/jhdp_in_reg.sv @@
// ----------------------------------------------------------------------------
// jhdp_in_reg
// input register stage holding one accepted byte item
// ----------------------------------------------------------------------------
module jhdp_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  jhdp_pkg::item_t in_item,
	input  logic            advance,
	output logic            valid_s1,
	output jhdp_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ src/jhdp_parser.sv @@
// ----------------------------------------------------------------------------
// jhdp_parser
// marker walk state and per-byte next-state and result logic
// ----------------------------------------------------------------------------
module jhdp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  jhdp_pkg::item_t   item_s1,
	input  logic              advance,
	output logic              res_valid,
	output jhdp_pkg::result_t res
);

	jhdp_pkg::phase_t phase_q, phase, phase_nxt;
	logic [7:0]       marker_q, marker_nxt;
	logic [7:0]       len_hi_q, len_hi_nxt;
	logic [15:0]      skip_q, skip_nxt;
	logic [2:0]       idx_q, idx_nxt;
	logic [15:0]      height_q, height_nxt;
	logic [7:0]       width_hi_q, width_hi_nxt;
	logic [7:0]       b;
	logic [15:0]      seg_len;

	assign b       = item_s1.data_byte;
	assign seg_len = {len_hi_q, b};

	always_comb begin
		phase        = item_s1.first_byte ? jhdp_pkg::PH_SOI1 : phase_q;
		phase_nxt    = phase;
		marker_nxt   = marker_q;
		len_hi_nxt   = len_hi_q;
		skip_nxt     = skip_q;
		idx_nxt      = idx_q;
		height_nxt   = height_q;
		width_hi_nxt = width_hi_q;
		res_valid    = 1'b0;
		res          = '0;
		res.probe_status = jhdp_pkg::ST_UNKNOWN;
		if (item_s1.end_of_data) begin
			if (phase != jhdp_pkg::PH_DONE) begin
				res_valid = 1'b1;
				phase_nxt = jhdp_pkg::PH_DONE;
			end
		end else begin
			unique case (phase)
				jhdp_pkg::PH_SOI1: begin
					if (b != jhdp_pkg::MK_FILL) begin
						res_valid = 1'b1;
						phase_nxt = jhdp_pkg::PH_DONE;
					end else begin
						phase_nxt = jhdp_pkg::PH_SOI2;
					end
				end
				jhdp_pkg::PH_SOI2: begin
					if (b != jhdp_pkg::MK_SOI) begin
						res_valid = 1'b1;
						phase_nxt = jhdp_pkg::PH_DONE;
					end else begin
						phase_nxt = jhdp_pkg::PH_MK0;
					end
				end
				jhdp_pkg::PH_MK0: begin
					if (b != jhdp_pkg::MK_FILL) begin
						res_valid = 1'b1;
						phase_nxt = jhdp_pkg::PH_DONE;
					end else begin
						phase_nxt = jhdp_pkg::PH_MK1;
					end
				end
				jhdp_pkg::PH_MK1: begin
					if (b == jhdp_pkg::MK_FILL) begin
						phase_nxt = jhdp_pkg::PH_MK1;
					end else if (b == jhdp_pkg::MK_TEM
						|| (b >= jhdp_pkg::MK_RST0 && b <= jhdp_pkg::MK_RST7)) begin
						phase_nxt = jhdp_pkg::PH_MK0;
					end else if (b == jhdp_pkg::MK_EOI || b == jhdp_pkg::MK_SOS) begin
						res_valid = 1'b1;
						phase_nxt = jhdp_pkg::PH_DONE;
					end else begin
						marker_nxt = b;
						phase_nxt  = jhdp_pkg::PH_LEN0;
					end
				end
				jhdp_pkg::PH_LEN0: begin
					len_hi_nxt = b;
					phase_nxt  = jhdp_pkg::PH_LEN1;
				end
				jhdp_pkg::PH_LEN1: begin
					if (marker_q == jhdp_pkg::MK_SOF0 || marker_q == jhdp_pkg::MK_SOF1) begin
						idx_nxt   = '0;
						phase_nxt = jhdp_pkg::PH_SOF;
					end else if (jhdp_pkg::is_unsupp_sof(marker_q)) begin
						res_valid        = 1'b1;
						res.probe_status = jhdp_pkg::ST_UNSUPP;
						phase_nxt        = jhdp_pkg::PH_DONE;
					end else if (seg_len < 16'd2) begin
						res_valid = 1'b1;
						phase_nxt = jhdp_pkg::PH_DONE;
					end else begin
						skip_nxt  = seg_len - 16'd2;
						phase_nxt = (seg_len == 16'd2) ? jhdp_pkg::PH_MK0 : jhdp_pkg::PH_SKIP;
					end
				end
				jhdp_pkg::PH_SKIP: begin
					skip_nxt = skip_q - 16'd1;
					if (skip_q == 16'd1) begin
						phase_nxt = jhdp_pkg::PH_MK0;
					end
				end
				jhdp_pkg::PH_SOF: begin
					idx_nxt = idx_q + 3'd1;
					case (idx_q)
						3'd1: height_nxt   = {b, 8'h00};
						3'd2: height_nxt   = {height_q[15:8], b};
						3'd3: width_hi_nxt = b;
						3'd0: ;
						default: begin
							res_valid        = 1'b1;
							res.probe_status = jhdp_pkg::ST_BASELINE;
							res.image_width  = {width_hi_q, b};
							res.image_height = height_q;
							phase_nxt        = jhdp_pkg::PH_DONE;
						end
					endcase
				end
				jhdp_pkg::PH_IDLE, jhdp_pkg::PH_DONE: ;
				default: phase_nxt = jhdp_pkg::PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= jhdp_pkg::PH_IDLE;
			marker_q   <= '0;
			len_hi_q   <= '0;
			skip_q     <= '0;
			idx_q      <= '0;
			height_q   <= '0;
			width_hi_q <= '0;
		end else if (advance) begin
			phase_q    <= phase_nxt;
			marker_q   <= marker_nxt;
			len_hi_q   <= len_hi_nxt;
			skip_q     <= skip_nxt;
			idx_q      <= idx_nxt;
			height_q   <= height_nxt;
			width_hi_q <= width_hi_nxt;
		end
	end

endmodule

@@ src/jhdp_out_reg.sv @@
// ----------------------------------------------------------------------------
// jhdp_out_reg
// result register facing the output stream
// ----------------------------------------------------------------------------
module jhdp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jhdp_pkg::result_t res,
	output logic              slot_free,
	output logic              out_valid,
	input  logic              out_ready,
	output jhdp_pkg::result_t res_q
);

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			res_q <= res;
		end
	end

endmodule

@@ src/jpeg_header_dimension_probe_top.sv @@
// ----------------------------------------------------------------------------
// jpeg_header_dimension_probe_top
// walks jpeg markers and reports the frame type and dimensions
// ----------------------------------------------------------------------------
// input stream: one file byte per item, tuser marks the first byte and end of data
// a file starts with an item whose first_byte flag is set; end_of_data closes
// it and carries no byte
// output stream: one result per file (status, width, height), width and
// height are zero unless the status is baseline
// throughput: one input item per cycle unless a result is held by a stalled receiver,
// set by the marker state update between the input register and the result register
// path: the deciding byte passes the input register, the parser and the result register
// reset: clears both registers and puts the parser back to waiting for a file
// while the receiver stalls, the result is held; bytes that give no result
// keep flowing, and the input register holds one item that would give a
// second result until the first is taken
// ----------------------------------------------------------------------------
module jpeg_header_dimension_probe_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic [1:0]  s_axis_tuser,   // first_byte, end_of_data
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // probe_status, image_width, image_height
);

	jhdp_pkg::item_t   in_item;
	jhdp_pkg::item_t   item_s1;
	jhdp_pkg::result_t res;
	jhdp_pkg::result_t res_q;
	logic              valid_s1;
	logic              advance;
	logic              res_valid;
	logic              slot_free;

	assign in_item.data_byte   = s_axis_tdata;
	assign in_item.first_byte  = s_axis_tuser[0];
	assign in_item.end_of_data = s_axis_tuser[1];

	assign advance = valid_s1 && (!res_valid || slot_free);

	jhdp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	jhdp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	jhdp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_q     (res_q)
	);

	assign m_axis_tdata = {6'b0, res_q};

endmodule

@@ src/jhdp_checker.sv @@
// ----------------------------------------------------------------------------
// jhdp_checker
// port-level checks for the jpeg header dimension probe
// ----------------------------------------------------------------------------
`include "jpeg_header_dimension_probe_top_assert.svh"

module jhdp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata
);

	logic in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	// stalled result stays put
	`JHDP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// status code is one of the three defined values
	`JHDP_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)

	// dimensions are only reported with a baseline status
	`JHDP_ASSERT_NOW(a_dims_zero, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd1),
		m_axis_tdata[39:2] == 38'd0)

	// an item that starts a file and ends its data, taken with no result waiting, yields a result
	`JHDP_ASSERT_NEXT(a_empty_file, in_fire && (s_axis_tuser == 2'b11) && !m_axis_tvalid,
		##1 m_axis_tvalid)

endmodule

bind jpeg_header_dimension_probe_top jhdp_checker u_jhdp_checker (.*);
